// File: hdl/cidracl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cidracl_pkg
// Shared types and constants of the prefix access list matcher: operation
// codes, family prefix limits, and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package cidracl_pkg;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam logic [7:0] V4_MAX_PLEN = 8'd32;
    localparam logic [7:0] V6_MAX_PLEN = 8'd128;
    localparam int         ADDR_BITS   = 128;
    localparam int         OUT_IDX_W   = 4;
    localparam int         OUT_CNT_W   = 5;

    typedef struct packed {
        logic capture;      // word accepted: latch request, update table, clear votes
        logic issue;        // read the rule at the walk pointer and advance
        logic load_result;  // move the verdict into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic last_issue;   // walk pointer sits on the final slot
    } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/cidracl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cidracl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cidracl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/cidracl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cidracl_ctrl
// Sequencer: accepts one word at a time, runs the table walk for checks and
// hands the verdict to the output register.
// ----------------------------------------------------------------------------
module cidracl_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_operation,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output cidracl_pkg::dp_cmd_t         cmd,
    input  wire cidracl_pkg::dp_status_t status
);
    import cidracl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd             = '0;
        cmd.capture     = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op_t'(s_operation) == OP_CHECK) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_WALK: begin
                cmd.issue = 1'b1;
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last rule read is evaluated this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/cidracl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cidracl_dp
// Rule table and match datapath: occupancy flags, rule RAM, walk pointer,
// one-rule-per-cycle prefix compare and the deny/allow vote registers.
// ----------------------------------------------------------------------------
module cidracl_dp #(
    parameter int RULE_SLOTS   = 16,
    parameter int APP_TAG_BITS = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cidracl_pkg::dp_cmd_t    cmd,
    output cidracl_pkg::dp_status_t      status,
    input  wire logic [1:0]              s_operation,
    input  wire logic [3:0]              s_rule_index,
    input  wire logic [63:0]             s_addr_hi,
    input  wire logic [63:0]             s_addr_lo,
    input  wire logic                    s_is_ipv6,
    input  wire logic [7:0]              s_prefix_len,
    input  wire logic                    s_deny_action,
    input  wire logic [7:0]              s_app_tag,
    output logic                         m_allowed,
    output logic                         m_rule_matched,
    output logic [3:0]                   m_matched_index,
    output logic [4:0]                   m_rule_count
);
    import cidracl_pkg::*;

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int TAG_W = (APP_TAG_BITS < 8) ? APP_TAG_BITS : 8;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);
    localparam int ENT_W = ADDR_BITS + 3 + 8 + TAG_W;

    // table state
    logic [RULE_SLOTS-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // latched request
    logic [ADDR_BITS-1:0]  req_addr_reg;
    logic                  req_v6_reg;
    logic [TAG_W-1:0]      req_tag_reg;

    // walk and votes
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      eval_idx_reg;
    logic                  eval_vld_reg;
    logic                  have_deny_reg, have_allow_reg;
    logic [IDX_W-1:0]      deny_idx_reg, allow_idx_reg;

    // result register
    logic                  allowed_reg, matched_reg;
    logic [IDX_W-1:0]      midx_reg;
    logic [CNT_W-1:0]      rcount_reg;

    // write side
    op_t                   op;
    logic [31:0]           idx_wide;
    logic [IDX_W-1:0]      wr_slot;
    logic                  in_range;
    logic                  plen_ok;
    logic                  ram_we;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;

    // read side
    logic [ADDR_BITS-1:0]  ent_addr;
    logic                  ent_valid, ent_v6, ent_deny;
    logic [7:0]            ent_plen;
    logic [TAG_W-1:0]      ent_tag;
    logic [ADDR_BITS-1:0]  pfx_mask;
    logic                  hit;
    logic [IDX_W-1:0]      sel_idx;
    logic [31:0]           midx_wide;
    logic [31:0]           cnt_wide;

    assign op       = op_t'(s_operation);
    assign idx_wide = 32'(s_rule_index);
    assign wr_slot  = idx_wide[IDX_W-1:0];
    assign in_range = (idx_wide < 32'(RULE_SLOTS));
    assign plen_ok  = s_is_ipv6 ? (s_prefix_len <= V6_MAX_PLEN)
                                : (s_prefix_len <= V4_MAX_PLEN);
    assign ram_we   = cmd.capture && (op == OP_WRITE) && in_range;
    assign ram_wdata = {s_addr_hi, s_addr_lo, plen_ok, s_is_ipv6, s_deny_action,
                        s_prefix_len, s_app_tag[TAG_W-1:0]};

    cidracl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RULE_SLOTS)
    ) u_rules (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_slot),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign {ent_addr, ent_valid, ent_v6, ent_deny, ent_plen, ent_tag} = ram_rdata;

    // thermometer mask: top ent_plen bits set
    always_comb begin
        for (int j = 0; j < ADDR_BITS; j++) begin
            pfx_mask[ADDR_BITS-1-j] = (8'(j) < ent_plen);
        end
    end

    assign hit = eval_vld_reg && occ_reg[eval_idx_reg] && ent_valid
              && (ent_v6 == req_v6_reg)
              && ((ent_tag == '0) || (ent_tag == req_tag_reg))
              && (((ent_addr ^ req_addr_reg) & pfx_mask) == '0);

    assign status.last_issue = (rd_idx_reg == IDX_W'(RULE_SLOTS - 1));

    always_comb begin
        occ_next   = occ_reg;
        count_next = count_reg;
        if (cmd.capture) begin
            case (op)
                OP_WRITE: begin
                    if (in_range) begin
                        occ_next[wr_slot] = 1'b1;
                        if (!occ_reg[wr_slot]) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                OP_REMOVE: begin
                    if (in_range && occ_reg[wr_slot]) begin
                        occ_next[wr_slot] = 1'b0;
                        count_next        = count_reg - CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    occ_next   = '0;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            count_reg    <= '0;
            eval_vld_reg <= 1'b0;
        end else begin
            occ_reg      <= occ_next;
            count_reg    <= count_next;
            eval_vld_reg <= cmd.issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_addr_reg   <= {s_addr_hi, s_addr_lo};
            req_v6_reg     <= s_is_ipv6;
            req_tag_reg    <= s_app_tag[TAG_W-1:0];
            rd_idx_reg     <= '0;
            have_deny_reg  <= 1'b0;
            have_allow_reg <= 1'b0;
            deny_idx_reg   <= '0;
            allow_idx_reg  <= '0;
        end else begin
            if (cmd.issue) begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            // first deny wins, last allow wins
            if (hit && ent_deny && !have_deny_reg) begin
                have_deny_reg <= 1'b1;
                deny_idx_reg  <= eval_idx_reg;
            end
            if (hit && !ent_deny) begin
                have_allow_reg <= 1'b1;
                allow_idx_reg  <= eval_idx_reg;
            end
        end
        if (cmd.issue) begin
            eval_idx_reg <= rd_idx_reg;
        end
    end

    always_comb begin
        if (have_deny_reg) begin
            sel_idx = deny_idx_reg;
        end else if (have_allow_reg) begin
            sel_idx = allow_idx_reg;
        end else begin
            sel_idx = '0;
        end
    end

    // hold the count with the verdict so a waiting result stays put
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            allowed_reg <= !have_deny_reg;
            matched_reg <= have_deny_reg || have_allow_reg;
            midx_reg    <= sel_idx;
            rcount_reg  <= count_reg;
        end
    end

    assign midx_wide       = 32'(midx_reg);
    assign cnt_wide        = 32'(rcount_reg);
    assign m_allowed       = allowed_reg;
    assign m_rule_matched  = matched_reg;
    assign m_matched_index = midx_wide[OUT_IDX_W-1:0];
    assign m_rule_count    = cnt_wide[OUT_CNT_W-1:0];

endmodule
`default_nettype wire

// File: hdl/cidr_acl_deny_first_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cidr_acl_deny_first_matcher
// IP prefix access list with deny-first matching: write, remove and clear
// maintain the rule table; a check walks it and returns the verdict.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  operation, rule_index, addr_hi,
//                                          addr_lo, is_ipv6, prefix_len,
//                                          deny_action, app_tag
//   m_       out        m_valid / m_ready  allowed, rule_matched,
//                                          matched_index, rule_count
//
// A check raises m_valid after the walk: one rule RAM read per cycle, then
// the last read is scored in the drain state and the result is loaded once
// the output is free. Write, remove and clear go straight to the load. s_ready
// returns the cycle after the load, so a new word is taken only once the last
// one's result is loaded. A result waiting on m_ready does not block the next
// accept, only the next load. Reset clears the occupancy flags at once.
// ----------------------------------------------------------------------------
module cidr_acl_deny_first_matcher #(
    parameter int RULE_SLOTS   = 16,
    parameter int APP_TAG_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [3:0]  s_rule_index,
    input  wire logic [63:0] s_addr_hi,
    input  wire logic [63:0] s_addr_lo,
    input  wire logic        s_is_ipv6,
    input  wire logic [7:0]  s_prefix_len,
    input  wire logic        s_deny_action,
    input  wire logic [7:0]  s_app_tag,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_allowed,
    output logic             m_rule_matched,
    output logic [3:0]       m_matched_index,
    output logic [4:0]       m_rule_count
);
    import cidracl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cidracl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    cidracl_dp #(
        .RULE_SLOTS   (RULE_SLOTS),
        .APP_TAG_BITS (APP_TAG_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_operation     (s_operation),
        .s_rule_index    (s_rule_index),
        .s_addr_hi       (s_addr_hi),
        .s_addr_lo       (s_addr_lo),
        .s_is_ipv6       (s_is_ipv6),
        .s_prefix_len    (s_prefix_len),
        .s_deny_action   (s_deny_action),
        .s_app_tag       (s_app_tag),
        .m_allowed       (m_allowed),
        .m_rule_matched  (m_rule_matched),
        .m_matched_index (m_matched_index),
        .m_rule_count    (m_rule_count)
    );

endmodule
`default_nettype wire
